@@ src/table_linear_interpolator_macros.svh @@
// Assertion macros for the interpolator RTL
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication
`define TLI_CHECK_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TLI_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tli_pkg.sv @@
// Shared constants for the table linear interpolator
`timescale 1ns / 1ps

package tli_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_DATA_WIDTH  = 16;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

endpackage

@@ src/tli_ram.sv @@
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tli_lerp.sv @@
// Interpolation unit: one multiply, shift-subtract divide, add and saturate
`timescale 1ns / 1ps

module tli_lerp #(
    parameter int DATA_WIDTH = tli_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_x0,
    input  logic signed [DATA_WIDTH-1:0] i_y0,
    input  logic signed [DATA_WIDTH-1:0] i_x1,
    input  logic signed [DATA_WIDTH-1:0] i_y1,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_value
);

    localparam int DW   = DATA_WIDTH;
    localparam int CNTW = $clog2(DW);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_ADD  = 4'b1000
    } t_lerp_state;

    t_lerp_state r_state, n_state;
    logic               r_neg, n_neg;
    logic signed [DW-1:0] r_y0, n_y0;
    logic [DW-1:0]      r_mag, n_mag;
    logic [DW-1:0]      r_num, n_num;
    logic [DW-1:0]      r_den, n_den;
    logic [DW-1:0]      r_rem, n_rem;
    logic [DW-1:0]      r_low, n_low;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic               r_done, n_done;
    logic signed [DW-1:0] r_value, n_value;

    logic [DW:0]   w_dy;
    logic [DW:0]   w_mag;
    logic [DW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic [2*DW-1:0] w_prod;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW:0]   w_sum;
    logic [DW-1:0] w_sat;

    assign w_dy    = {i_y1[DW-1], i_y1} - {i_y0[DW-1], i_y0};
    assign w_mag   = w_dy[DW] ? (~w_dy + 1'b1) : w_dy;
    assign w_num   = i_x - i_x0;
    assign w_den   = i_x1 - i_x0;
    assign w_prod  = {{DW{1'b0}}, r_mag} * {{DW{1'b0}}, r_num};
    assign w_trial = {r_rem, r_low[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_sum   = r_neg ? ({r_y0[DW-1], r_y0} - {1'b0, r_low})
                           : ({r_y0[DW-1], r_y0} + {1'b0, r_low});

    always_comb begin
        if (w_sum[DW] != w_sum[DW-1]) begin
            w_sat = w_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            w_sat = w_sum[DW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_y0    = r_y0;
        n_mag   = r_mag;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_low   = r_low;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_value = r_value;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_neg   = w_dy[DW];
                    n_mag   = w_mag[DW-1:0];
                    n_num   = w_num;
                    n_den   = w_den;
                    n_y0    = i_y0;
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                {n_rem, n_low} = w_prod;
                n_cnt   = CNTW'(DW - 1);
                n_state = L_DIV;
            end
            L_DIV: begin
                n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                n_low = {r_low[DW-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = L_ADD;
                end
            end
            L_ADD: begin
                n_value = w_sat;
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_neg   <= n_neg;
        r_y0    <= n_y0;
        r_mag   <= n_mag;
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_low   <= n_low;
        r_cnt   <= n_cnt;
        r_value <= n_value;
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

@@ src/table_linear_interpolator.sv @@
// Piecewise linear interpolation table: top level
//
// Breakpoints sit in one RAM of TABLE_DEPTH (x, y) words with a registered
// read. Clear, load, an unused op and a query rejected up front (empty
// table, table not ascending, x outside first..last abscissa) give their
// result in the cycle after start, and busy stays low, so such commands may
// be issued every cycle. Any other query raises busy and scans the table one
// entry per cycle through the single RAM read port. An exact match ends the
// scan and returns the stored y. When x falls strictly between two
// breakpoints, one multiply, a DATA_WIDTH-step shift-subtract divide and a
// saturating add follow. Each result appears on o_result_value and o_status
// for exactly one cycle with o_valid high; the receiver must take it then, as
// there is no back-pressure.
`timescale 1ns / 1ps

`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = tli_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_x_value,
    input  logic signed [DATA_WIDTH-1:0] i_y_value,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_value,
    output logic [1:0]                   o_status
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LERP = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_asc, n_asc;
    logic signed [DW-1:0] r_first_x, n_first_x;
    logic signed [DW-1:0] r_last_x, n_last_x;
    logic signed [DW-1:0] r_qx, n_qx;
    logic [CW-1:0]        r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic                 r_have_prev, n_have_prev;
    logic signed [DW-1:0] r_px, n_px;
    logic signed [DW-1:0] r_py, n_py;
    logic                 r_valid, n_valid;
    logic signed [DW-1:0] r_result, n_result;
    logic [1:0]           r_status, n_status;

    logic                 w_we;
    logic                 w_re;
    logic [2*DW-1:0]      w_rdata;
    logic signed [DW-1:0] w_rd_x;
    logic signed [DW-1:0] w_rd_y;
    logic                 w_lerp_start;
    logic                 w_lerp_done;
    logic signed [DW-1:0] w_lerp_value;

    assign w_rd_x = w_rdata[2*DW-1:DW];
    assign w_rd_y = w_rdata[DW-1:0];

    tli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_x_value, i_y_value}),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    tli_lerp #(
        .DATA_WIDTH (DW)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_x0    (r_px),
        .i_y0    (r_py),
        .i_x1    (w_rd_x),
        .i_y1    (w_rd_y),
        .i_x     (r_qx),
        .o_done  (w_lerp_done),
        .o_value (w_lerp_value)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_asc        = r_asc;
        n_first_x    = r_first_x;
        n_last_x     = r_last_x;
        n_qx         = r_qx;
        n_addr       = r_addr;
        n_pend       = 1'b0;
        n_have_prev  = r_have_prev;
        n_px         = r_px;
        n_py         = r_py;
        n_valid      = 1'b0;
        n_result     = r_result;
        n_status     = r_status;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_lerp_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_result = '0;
                    n_status = tli_pkg::STAT_OK;
                    case (i_op)
                        tli_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_asc   = 1'b1;
                        end
                        tli_pkg::OP_LOAD: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_status = tli_pkg::STAT_FULL;
                            end else begin
                                w_we = 1'b1;
                                if (r_count == '0) begin
                                    n_first_x = i_x_value;
                                end else if (r_last_x > i_x_value) begin
                                    n_asc = 1'b0;
                                end
                                n_last_x = i_x_value;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        tli_pkg::OP_QUERY: begin
                            if (r_count == '0) begin
                                n_status = tli_pkg::STAT_RANGE;
                            end else if (!r_asc) begin
                                n_status = tli_pkg::STAT_ORDER;
                            end else if (i_x_value < r_first_x || i_x_value > r_last_x) begin
                                n_status = tli_pkg::STAT_RANGE;
                            end else begin
                                n_valid     = 1'b0;
                                n_qx        = i_x_value;
                                n_addr      = '0;
                                n_have_prev = 1'b0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_addr < r_count) begin
                    w_re   = 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    if (w_rd_x == r_qx) begin
                        n_valid  = 1'b1;
                        n_result = w_rd_y;
                        n_status = tli_pkg::STAT_OK;
                        n_pend   = 1'b0;
                        n_state  = ST_IDLE;
                    end else if (r_have_prev && r_px < r_qx && r_qx < w_rd_x) begin
                        w_lerp_start = 1'b1;
                        n_pend       = 1'b0;
                        n_state      = ST_LERP;
                    end else begin
                        n_px        = w_rd_x;
                        n_py        = w_rd_y;
                        n_have_prev = 1'b1;
                    end
                end else if (r_addr >= r_count) begin
                    n_valid  = 1'b1;
                    n_result = '0;
                    n_status = tli_pkg::STAT_RANGE;
                    n_state  = ST_IDLE;
                end
            end
            ST_LERP: begin
                if (w_lerp_done) begin
                    n_valid  = 1'b1;
                    n_result = w_lerp_value;
                    n_status = tli_pkg::STAT_OK;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_asc       <= 1'b1;
            r_pend      <= 1'b0;
            r_have_prev <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_asc       <= n_asc;
            r_pend      <= n_pend;
            r_have_prev <= n_have_prev;
            r_valid     <= n_valid;
        end
        r_first_x <= n_first_x;
        r_last_x  <= n_last_x;
        r_qx      <= n_qx;
        r_addr    <= n_addr;
        r_px      <= n_px;
        r_py      <= n_py;
        r_result  <= n_result;
        r_status  <= n_status;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    `TLI_CHECK_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH),
        "entry count exceeds table depth")
    `TLI_CHECK_NEXT(a_load_advance, i_clk, i_rst_n,
        start && !busy && i_op == tli_pkg::OP_LOAD && r_count < CW'(TABLE_DEPTH),
        r_count == $past(r_count) + 1'b1, "load did not advance entry count")
    `TLI_CHECK_SAME(a_status_zero, i_clk, i_rst_n, o_valid && o_status != tli_pkg::STAT_OK,
        o_result_value == '0, "failed transaction carries non-zero result")
    `TLI_CHECK_SAME(a_lerp_owner, i_clk, i_rst_n, w_lerp_done, r_state == ST_LERP,
        "interpolation unit finished outside its wait state")

endmodule
